// File: rtl/bbal_pkg.sv
// Package with the shared constants, codes and types of the byte bitmap allocator.
package bbal_pkg;

    localparam int FIELD_W = 13;
    localparam int ARENA_BYTES_DEF = 8192;
    localparam int MAX_REQUEST_DEF = 4096;
    localparam int HEADER_BYTES_DEF = 4;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE = 1'b1;

    // Access requests from the sequencer to the storage.
    typedef struct packed {
        logic                  bm_we;
        logic                  bm_wdata;
        logic [31:0]           bm_addr;
        logic                  sz_we;
        logic [31:0]           sz_addr;
        logic [FIELD_W-1:0]    sz_wdata;
    } store_req_t;

endpackage

// File: rtl/bbal_store.sv
// Storage of the allocator: the used bitmap and the recorded block sizes.
module bbal_store #(
    parameter int ARENA_BYTES = bbal_pkg::ARENA_BYTES_DEF
) (
    input  logic                       clk,
    input  bbal_pkg::store_req_t       req,
    output logic                       bm_rdata,
    output logic [bbal_pkg::FIELD_W-1:0] sz_rdata
);
    import bbal_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES);

    logic               used_mem [ARENA_BYTES];
    logic [FIELD_W-1:0] size_mem [ARENA_BYTES];
    logic               bm_rdata_reg;
    logic [FIELD_W-1:0] sz_rdata_reg;

    // Bitmap: one access a cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (req.bm_we)
        begin
            used_mem[req.bm_addr[AW-1:0]] <= req.bm_wdata;
        end
        bm_rdata_reg <= used_mem[req.bm_addr[AW-1:0]];
    end

    // Size table: written at allocation, read at free.
    always_ff @(posedge clk)
    begin
        if (req.sz_we)
        begin
            size_mem[req.sz_addr[AW-1:0]] <= req.sz_wdata;
        end
        sz_rdata_reg <= size_mem[req.sz_addr[AW-1:0]];
    end

    assign bm_rdata = bm_rdata_reg;
    assign sz_rdata = sz_rdata_reg;

endmodule

// File: rtl/byte_bitmap_allocator.sv
// Byte bitmap first-fit allocator: sequencer, output register and storage.
// An alloc tries candidates in turn; for each it reads and checks the header and payload
// bits one at a time (a read state, then a check state) and on a free run marks one bit per
// cycle; a free reads the recorded size, then clears the block's bits. One word at a time.
// The result is held in an output register; a new word is taken once it has been delivered.
// After reset the bitmap is cleared one byte a cycle, with input stalled.
// The recorded sizes are not cleared.
module byte_bitmap_allocator #(
    parameter int ARENA_BYTES = bbal_pkg::ARENA_BYTES_DEF,
    parameter int MAX_REQUEST = bbal_pkg::MAX_REQUEST_DEF,
    parameter int HEADER_BYTES = bbal_pkg::HEADER_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [bbal_pkg::FIELD_W-1:0] req_size,
    input  logic [bbal_pkg::FIELD_W-1:0] block_offset,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [bbal_pkg::FIELD_W-1:0] payload_offset
);
    import bbal_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 2;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CAND  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_MARK  = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;
    localparam logic [3:0] S_CLR   = 4'd8;

    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
    localparam logic [CW-1:0] HDR_C = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXREQ_C = CW'(MAX_REQUEST);

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      size_reg, size_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [FIELD_W-1:0] payload_reg, payload_next;

    store_req_t         req;
    logic               bm_rdata;
    logic [FIELD_W-1:0] sz_rdata;

    logic [CW-1:0]      size_in;
    logic [CW-1:0]      off_in;
    logic [CW-1:0]      cand_end;
    logic               accept;

    bbal_store #(
        .ARENA_BYTES(ARENA_BYTES)
    ) u_store (
        .clk      (clk),
        .req      (req),
        .bm_rdata (bm_rdata),
        .sz_rdata (sz_rdata)
    );

    assign size_in  = CW'(req_size);
    assign off_in   = CW'(block_offset);
    assign cand_end = i_reg + size_reg;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    // Sequencer: scans candidates, marks and clears runs of bitmap bits.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        payload_next   = payload_reg;
        req            = '0;
        req.bm_addr    = 32'(k_reg);
        req.sz_addr    = 32'(k_reg);
        req.sz_wdata   = size_reg[FIELD_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                req.bm_we = 1'b1;
                k_next = k_reg + 1'b1;
                if (k_reg == ARENA_C - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next = size_in;
                    if (func == FUNC_ALLOC)
                    begin
                        if (size_in == '0 || size_in > MAXREQ_C)
                        begin
                            out_valid_next = 1'b1;
                            status_next = STATUS_BAD_SIZE;
                            payload_next = '0;
                        end
                        else
                        begin
                            i_next = (size_in < HDR_C) ? HDR_C : size_in;
                            state_next = S_CAND;
                        end
                    end
                    else if (off_in >= HDR_C && off_in < ARENA_C)
                    begin
                        k_next = off_in - HDR_C;
                        state_next = S_FRD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next = STATUS_DONE;
                        payload_next = '0;
                    end
                end
            end
            S_CAND:
            begin
                if (cand_end >= ARENA_C || cand_end < i_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next = STATUS_NO_SPACE;
                    payload_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = i_reg - HDR_C;
                    cnt_next = size_reg + HDR_C;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (bm_rdata)
                begin
                    i_next = i_reg + size_reg;
                    state_next = S_CAND;
                end
                else if (cnt_reg == CW'(1))
                begin
                    // Whole run is free: record the size at the header.
                    req.sz_we = 1'b1;
                    req.sz_addr = 32'(i_reg - HDR_C);
                    k_next = i_reg - HDR_C;
                    cnt_next = size_reg + HDR_C;
                    state_next = S_MARK;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_RD;
                end
            end
            S_MARK:
            begin
                req.bm_we = 1'b1;
                req.bm_wdata = 1'b1;
                k_next = k_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    out_valid_next = 1'b1;
                    status_next = STATUS_DONE;
                    payload_next = i_reg[FIELD_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_FRD:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                cnt_next = CW'(sz_rdata) + HDR_C;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                if (cnt_reg == '0 || k_reg >= ARENA_C)
                begin
                    out_valid_next = 1'b1;
                    status_next = STATUS_DONE;
                    payload_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    req.bm_we = 1'b1;
                    k_next = k_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        cnt_reg <= cnt_next;
        size_reg <= size_next;
        status_reg <= status_next;
        payload_reg <= payload_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign payload_offset = payload_reg;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the byte bitmap first-fit allocator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbal_pkg::*;

    localparam int ARENA = ARENA_BYTES_DEF;
    localparam int HDR = HEADER_BYTES_DEF;
    localparam int MAXREQ = MAX_REQUEST_DEF;
    localparam int RANDOM_WORDS = 900;
    localparam int LIVE_CAP = 24;
    localparam longint CYCLE_LIMIT = 400_000_000;
    localparam int DRAIN_CYCLES = 12000;

    // One request word together with the response that the shadow arena predicts.
    typedef struct {
        logic               op;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] offset;
        logic [1:0]         want_status;
        logic [FIELD_W-1:0] want_offset;
    } alloc_word_t;

    typedef struct {
        logic [1:0]         status;
        logic [FIELD_W-1:0] offset;
    } reply_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [FIELD_W-1:0] req_size;
    logic [FIELD_W-1:0] block_offset;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [FIELD_W-1:0] payload_offset;

    // Shadow arena: used bit per byte, recorded size per header and whether it was written.
    bit                 shadow_used [ARENA];
    logic [FIELD_W-1:0] shadow_size [ARENA];
    bit                 size_written [ARENA];

    alloc_word_t        pending_words [$];
    reply_t             awaited_replies [$];
    int                 live_blocks [$];
    int                 freed_blocks [$];

    int     error_count;
    int     send_gap;
    int     hold_left;
    int     replies_seen;
    int     stall_mode;
    longint cycle_count;
    bit     stimulus_done;
    bit     word_taken;

    byte_bitmap_allocator DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .req_size(req_size),
        .block_offset(block_offset),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .payload_offset(payload_offset)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch on %s: got %0d, expected %0d (reply %0d)", what, got, want,
                 replies_seen);
    endtask

    function automatic bit span_free(int start, int len);
        for (int k = start; k < start + len; k++)
        begin
            if (k >= ARENA || shadow_used[k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void set_span(int start, int len, bit v);
        for (int k = start; k < start + len && k < ARENA; k++)
            shadow_used[k] = v;
    endfunction

    // First-fit search on the shadow arena; returns the payload offset or -1.
    function automatic int first_fit(int size);
        int pos;
        pos = (size < HDR) ? HDR : size;
        for (; pos + size < ARENA; pos += size)
        begin
            if (span_free(pos - HDR, size + HDR))
                return pos;
        end
        return -1;
    endfunction

    // Apply one request word to the shadow arena and queue it with its predicted reply.
    task automatic queue_word(input logic op, input int size, input int offset);
        alloc_word_t w;
        int pos;
        int hdr;
        w.op = op;
        w.size = size[FIELD_W-1:0];
        w.offset = offset[FIELD_W-1:0];
        w.want_status = STATUS_DONE;
        w.want_offset = '0;
        if (op == FUNC_ALLOC)
        begin
            if (w.size == 0 || w.size > MAXREQ)
                w.want_status = STATUS_BAD_SIZE;
            else
            begin
                pos = first_fit(w.size);
                if (pos < 0)
                    w.want_status = STATUS_NO_SPACE;
                else
                begin
                    set_span(pos - HDR, w.size + HDR, 1'b1);
                    shadow_size[pos - HDR] = w.size;
                    size_written[pos - HDR] = 1'b1;
                    w.want_offset = pos[FIELD_W-1:0];
                    live_blocks.push_back(pos);
                end
            end
        end
        else if (w.offset >= HDR)
        begin
            hdr = w.offset - HDR;
            set_span(hdr, shadow_size[hdr] + HDR, 1'b0);
        end
        pending_words.push_back(w);
    endtask

    // Free one live block chosen at random.
    task automatic free_live();
        int idx;
        int pos;
        idx = $urandom_range(live_blocks.size() - 1);
        pos = live_blocks[idx];
        live_blocks.delete(idx);
        freed_blocks.push_back(pos);
        queue_word(FUNC_FREE, $urandom_range(8191), pos);
    endtask

    // Stimulus: directed corner cases, then a random mix of allocs and frees.
    initial
    begin
        int roll;
        int size;
        int pos;
        int big_allocs;
        big_allocs = 0;
        queue_word(FUNC_ALLOC, 1, 8191);
        queue_word(FUNC_ALLOC, 2, 0);
        queue_word(FUNC_ALLOC, 3, 0);
        queue_word(FUNC_ALLOC, 4, 0);
        queue_word(FUNC_ALLOC, 0, 0);
        queue_word(FUNC_ALLOC, MAXREQ + 1, 0);
        queue_word(FUNC_ALLOC, 8191, 0);
        queue_word(FUNC_ALLOC, MAXREQ, 0);
        queue_word(FUNC_ALLOC, 4000, 0);
        queue_word(FUNC_ALLOC, 2000, 0);
        // Free the large block, then fill the arena in 2000-byte steps up to the top half.
        pos = live_blocks[4];
        live_blocks.delete(4);
        freed_blocks.push_back(pos);
        queue_word(FUNC_FREE, 0, pos);
        queue_word(FUNC_ALLOC, 2000, 0);
        queue_word(FUNC_ALLOC, 2000, 0);
        queue_word(FUNC_ALLOC, 2000, 0);
        queue_word(FUNC_FREE, 8191, 0);
        queue_word(FUNC_FREE, 0, HDR - 1);
        // Double free of the block freed above.
        queue_word(FUNC_FREE, 0, pos);
        while (live_blocks.size() > 2)
            free_live();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            roll = $urandom_range(99);
            if (live_blocks.size() >= LIVE_CAP || (roll < 40 && live_blocks.size() > 0))
                free_live();
            else if (roll < 45)
            begin
                // Stray frees: below the header or a repeat free of an old block.
                if (freed_blocks.size() > 0 && $urandom_range(1))
                    queue_word(FUNC_FREE, $urandom_range(8191),
                               freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
                else
                    queue_word(FUNC_FREE, $urandom_range(8191), $urandom_range(HDR - 1));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    size = $urandom_range(16, 1);
                else if (roll < 90)
                    size = $urandom_range(256, 17);
                else if (roll < 95 && big_allocs < 40)
                begin
                    size = $urandom_range(MAXREQ, 257);
                    big_allocs++;
                end
                else if (roll < 97)
                    size = 0;
                else
                    size = $urandom_range(8191, MAXREQ + 1);
                queue_word(FUNC_ALLOC, size, $urandom_range(8191));
            end
        end
        stimulus_done = 1'b1;
    end

    // Reset and initial drive values.
    initial
    begin
        error_count = 0;
        send_gap = 0;
        hold_left = 0;
        replies_seen = 0;
        stall_mode = 0;
        cycle_count = 0;
        in_valid = 1'b0;
        func = FUNC_ALLOC;
        req_size = '0;
        block_offset = '0;
        out_stall = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: record accepted words at the rising edge, present the next at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            awaited_replies.push_back('{pending_words[0].want_status,
                                        pending_words[0].want_offset});
            void'(pending_words.pop_front());
            send_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
            word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (word_taken)
        begin
            // The word just went; the next one follows after its gap.
            word_taken = 1'b0;
            if (send_gap == 0 && pending_words.size() > 0)
            begin
                in_valid <= 1'b1;
                func <= pending_words[0].op;
                req_size <= pending_words[0].size;
                block_offset <= pending_words[0].offset;
            end
            else
                in_valid <= 1'b0;
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_words.size() > 0)
            begin
                in_valid <= 1'b1;
                func <= pending_words[0].op;
                req_size <= pending_words[0].size;
                block_offset <= pending_words[0].offset;
            end
        end
    end

    // Monitor: compare each delivered reply with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
                report_mismatch("unexpected reply count", 1, 0);
            else
            begin
                if (status !== awaited_replies[0].status)
                    report_mismatch("status", status, awaited_replies[0].status);
                if (payload_offset !== awaited_replies[0].offset)
                    report_mismatch("payload_offset", payload_offset,
                                    awaited_replies[0].offset);
                void'(awaited_replies.pop_front());
            end
            replies_seen++;
            if (replies_seen % 60 == 0)
                stall_mode = $urandom_range(2);
            // One long hold-off so that the sender backs up behind a full block.
            if (replies_seen == 200)
                hold_left = 600;
            else if (stall_mode == 0)
                hold_left = 0;
            else
                hold_left = $urandom_range(15);
        end
    end

    // Receiver stall, counted down in cycles.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(7) == 0);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // End of run: wait for the last reply, then a drain window for stray output.
    initial
    begin
        wait (stimulus_done);
        wait (pending_words.size() == 0 && awaited_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && awaited_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
